### hdl/pwbh_pkg.sv
// Shared types and constants of the PID controller with balance hold.
// Used by the interfaces, the state unit, the top level and the checker.
`timescale 1ns / 1ps

package pwbh_pkg;

    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DER_W   = ERR_W + 1;
    localparam int INT_W   = 32;
    localparam int FRAC_W  = 12;
    localparam int PROD_P_W = DATA_W + ERR_W;
    localparam int PROD_I_W = DATA_W + INT_W;
    localparam int PROD_D_W = DATA_W + DER_W;
    localparam int TOTAL_W = PROD_I_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam int FAR_LIMIT_DEF = 20;

    localparam logic signed [DATA_W-1:0] GAIN_P_RST = 16'sd1229;
    localparam logic signed [DATA_W-1:0] GAIN_I_RST = 16'sd41;
    localparam logic signed [DATA_W-1:0] GAIN_D_RST = 16'sd410;
    localparam logic [DATA_W-1:0] TARGET_RST  = 16'd0;
    localparam logic [DATA_W-1:0] BALANCE_RST = 16'd32768;
    localparam logic [DATA_W-1:0] NEAR_RST    = 16'd2;
    localparam logic [DATA_W-1:0] FAR_RST     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_ENABLE        = 3'd3,
        REG_TARGET_VALUE  = 3'd4,
        REG_BALANCE_POINT = 3'd5,
        REG_NEAR_BAND     = 3'd6,
        REG_FAR_BAND      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic                     enable;
        logic [DATA_W-1:0]        target_value;
        logic [DATA_W-1:0]        balance_point;
        logic [DATA_W-1:0]        near_band;
        logic [DATA_W-1:0]        far_band;
    } cfg_t;

    // operands of one item after the state update
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] isum;
        logic signed [DER_W-1:0] deriv;
        logic                    disabled;
        logic                    in_balance;
    } oper_t;

endpackage

### hdl/pwbh_if.sv
// Valid/ready channel interfaces for measurement items and drive items.
// Depends on pwbh_pkg for the field widths.
`timescale 1ns / 1ps

interface pwbh_in_if
    import pwbh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] measured_value;

    modport source (output valid, output measured_value, input ready);
    modport sink   (input valid, input measured_value, output ready);
endinterface

interface pwbh_out_if
    import pwbh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] drive_value;
    logic              disabled;
    logic              in_balance;

    modport source (output valid, output drive_value, output disabled, output in_balance,
                    input ready);
    modport sink   (input valid, input drive_value, input disabled, input in_balance,
                    output ready);
endinterface

### hdl/pwbh_state.sv
// Controller state: integral, parked sum, previous error, balance flag, far count.
// Forms the error, integral and derivative operands of one item. Uses pwbh_pkg.
`timescale 1ns / 1ps

module pwbh_state
    import pwbh_pkg::*;
#(
    parameter int FAR_LIMIT = FAR_LIMIT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              go,
    input  logic [DATA_W-1:0] meas,
    output oper_t             oper
);

    localparam int CNT_W = $clog2(FAR_LIMIT + 2);

    logic [INT_W-1:0]        integral_reg, integral_next;
    logic [INT_W-1:0]        held_reg, held_next;
    logic signed [ERR_W-1:0] prev_reg, prev_next;
    logic                    flag_reg, flag_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic signed [ERR_W-1:0] err_raw;
    logic signed [ERR_W-1:0] err_neg;
    logic [DATA_W-1:0]       mag;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] prev_use;
    logic [INT_W-1:0]        isum_base;
    logic [INT_W-1:0]        err_ext;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [DER_W-1:0] deriv;

    always_comb
    begin
        err_raw = $signed({1'b0, cfg.target_value}) - $signed({1'b0, meas});
        err_neg = -err_raw;
        mag     = err_raw[ERR_W-1] ? err_neg[DATA_W-1:0] : err_raw[DATA_W-1:0];
        cnt_inc = cnt_reg + CNT_W'(1);

        err       = err_raw;
        prev_use  = prev_reg;
        isum_base = integral_reg;
        held_next = held_reg;
        flag_next = flag_reg;
        cnt_next  = cnt_reg;

        if (mag < cfg.near_band)
        begin
            if (!flag_reg)
            begin
                flag_next = 1'b1;
                held_next = integral_reg;
                isum_base = '0;
            end
        end
        else
        begin
            if (flag_reg)
            begin
                flag_next = 1'b0;
                isum_base = held_reg;
            end
            if (mag > cfg.far_band)
            begin
                if (cnt_inc > CNT_W'(FAR_LIMIT))
                begin
                    // far-error clear: restart as if measuring zero
                    isum_base = '0;
                    held_next = '0;
                    prev_use  = '0;
                    flag_next = 1'b0;
                    cnt_next  = '0;
                    err       = $signed({1'b0, cfg.target_value});
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            else
            begin
                cnt_next = '0;
            end
        end

        err_ext       = INT_W'(err);
        integral_next = flag_next ? held_next + err_ext : isum_base + err_ext;
        deriv         = (prev_use != '0) ? DER_W'(err) - DER_W'(prev_use) : '0;
        prev_next     = err;

        oper.err        = cfg.enable ? err : '0;
        oper.isum       = cfg.enable ? $signed(integral_next) : '0;
        oper.deriv      = cfg.enable ? deriv : '0;
        oper.disabled   = !cfg.enable;
        oper.in_balance = cfg.enable ? flag_next : flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            held_reg     <= '0;
            prev_reg     <= '0;
            flag_reg     <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (go && cfg.enable)
        begin
            integral_reg <= integral_next;
            held_reg     <= held_next;
            prev_reg     <= prev_next;
            flag_reg     <= flag_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

### hdl/pid_with_balance_hold.sv
// Top level of the positional PID controller with balance hold and far-error clear.
// Depends on pwbh_pkg, pwbh_if and pwbh_state.
`timescale 1ns / 1ps

// One measurement item in, one drive item out, one item per clock sustained while
// the output is not stalled. An item passes four registers: input register, state
// update (integral, balance and far count, one item per cycle unless stalled), gain
// multiplies, and the final sum with truncation toward zero and the balance point.
// A stalled output holds the pipeline; the input register still takes one item
// while it is empty. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while no item is in flight; the block itself does not enforce this.
// Disabled items return drive 0.

module pid_with_balance_hold
    import pwbh_pkg::*;
#(
    parameter int FAR_LIMIT = FAR_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    pwbh_in_if.sink              meas_ch,
    pwbh_out_if.source           drive_ch
);

    cfg_t cfg_reg;

    logic              advance;
    logic              in_acc;
    logic              s0_valid_reg;
    logic [DATA_W-1:0] s0_meas_reg;
    oper_t             oper;

    logic              s1_valid_reg;
    oper_t             s1_oper_reg;

    logic                       s2_valid_reg;
    logic signed [PROD_P_W-1:0] s2_p_reg;
    logic signed [PROD_I_W-1:0] s2_i_reg;
    logic signed [PROD_D_W-1:0] s2_d_reg;
    logic                       s2_dis_reg;
    logic                       s2_bal_reg;

    logic signed [TOTAL_W-1:0] total;
    logic [DATA_W-1:0]         q_low;
    logic [DATA_W-1:0]         drive_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_drive_reg;
    logic              out_dis_reg;
    logic              out_bal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= GAIN_P_RST;
            cfg_reg.gain_i        <= GAIN_I_RST;
            cfg_reg.gain_d        <= GAIN_D_RST;
            cfg_reg.enable        <= 1'b1;
            cfg_reg.target_value  <= TARGET_RST;
            cfg_reg.balance_point <= BALANCE_RST;
            cfg_reg.near_band     <= NEAR_RST;
            cfg_reg.far_band      <= FAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:        cfg_reg.gain_p        <= $signed(cfg_data);
                REG_GAIN_I:        cfg_reg.gain_i        <= $signed(cfg_data);
                REG_GAIN_D:        cfg_reg.gain_d        <= $signed(cfg_data);
                REG_ENABLE:        cfg_reg.enable        <= cfg_data[0];
                REG_TARGET_VALUE:  cfg_reg.target_value  <= cfg_data;
                REG_BALANCE_POINT: cfg_reg.balance_point <= cfg_data;
                REG_NEAR_BAND:     cfg_reg.near_band     <= cfg_data;
                REG_FAR_BAND:      cfg_reg.far_band      <= cfg_data;
                default:           cfg_reg.far_band      <= cfg_reg.far_band;
            endcase
        end
    end

    assign advance       = !out_valid_reg || drive_ch.ready;
    assign meas_ch.ready = advance || !s0_valid_reg;
    assign in_acc        = meas_ch.valid && meas_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s0_meas_reg <= meas_ch.measured_value;
        end
    end

    pwbh_state #(
        .FAR_LIMIT(FAR_LIMIT)
    ) u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .go    (advance && s0_valid_reg),
        .meas  (s0_meas_reg),
        .oper  (oper)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_oper_reg   <= oper;
            s2_p_reg      <= cfg_reg.gain_p * s1_oper_reg.err;
            s2_i_reg      <= cfg_reg.gain_i * s1_oper_reg.isum;
            s2_d_reg      <= cfg_reg.gain_d * s1_oper_reg.deriv;
            s2_dis_reg    <= s1_oper_reg.disabled;
            s2_bal_reg    <= s1_oper_reg.in_balance;
            out_drive_reg <= drive_next;
            out_dis_reg   <= s2_dis_reg;
            out_bal_reg   <= s2_bal_reg;
        end
    end

    // Q.12 sum truncated toward zero; only the low 16 integer bits survive
    always_comb
    begin
        total = TOTAL_W'(s2_p_reg) + TOTAL_W'(s2_i_reg) + TOTAL_W'(s2_d_reg);
        q_low = total[FRAC_W+DATA_W-1:FRAC_W]
              + DATA_W'(total[TOTAL_W-1] && (total[FRAC_W-1:0] != '0));
        drive_next = s2_dis_reg ? '0 : cfg_reg.balance_point + q_low;
    end

    assign drive_ch.valid       = out_valid_reg;
    assign drive_ch.drive_value = out_drive_reg;
    assign drive_ch.disabled    = out_dis_reg;
    assign drive_ch.in_balance  = out_bal_reg;

endmodule

### hdl/pwbh_checker.sv
// Port-level checks on pid_with_balance_hold, attached by the bind below.
// Depends on pwbh_pkg for field widths.
`timescale 1ns / 1ps

module pwbh_checker
    import pwbh_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] drive_value,
    input logic              disabled,
    input logic              in_balance
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_value)
            && $stable(disabled) && $stable(in_balance))
        else $error("stalled drive item changed");

    // no result waiting means the block takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // an accepted item reaches the output when the output does not stall in between
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("drive item missing after accepted item");

endmodule

bind pid_with_balance_hold pwbh_checker u_pwbh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (meas_ch.valid),
    .in_ready    (meas_ch.ready),
    .out_valid   (drive_ch.valid),
    .out_ready   (drive_ch.ready),
    .drive_value (drive_ch.drive_value),
    .disabled    (drive_ch.disabled),
    .in_balance  (drive_ch.in_balance)
);
